FILE: src/ksps_pkg.sv
// ----------------------------------------------------------------------------
// ksps_pkg
// Shared codes, widths and controller/datapath bundles for the k smallest
// pair sums unit.
// ----------------------------------------------------------------------------
package ksps_pkg;

	localparam int VAL_W   = 32;
	localparam int SUM_W   = 33;
	localparam int LIMIT_W = 7;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

	// which (row, column) pair the list memories are addressed with
	typedef enum logic [1:0] {
		LS_ORIGIN,
		LS_BEST,
		LS_RIGHT,
		LS_DOWN
	} list_sel_t;

	typedef struct packed {
		logic      load;
		logic      run_start;
		logic      clear;
		logic      scan_init;
		logic      scan_step;
		logic      heap_rm_rd;
		logic      heap_move;
		logic      heap_push;
		logic      out_load;
		logic      out_empty;
		list_sel_t list_sel;
	} ksps_cmd_t;

	typedef struct packed {
		logic run_empty;
		logic scan_done;
		logic out_free;
		logic can_right;
		logic can_down;
		logic is_last;
	} ksps_status_t;

endpackage

FILE: src/ksps_ram.sv
// ----------------------------------------------------------------------------
// ksps_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ksps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/ksps_dp.sv
// ----------------------------------------------------------------------------
// ksps_dp
// Datapath: list memories, candidate memory with linear min scan, counters,
// limit register and the result register.
// ----------------------------------------------------------------------------
module ksps_dp #(
	parameter int MAX_LEN   = 64,
	parameter int MAX_PAIRS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [ksps_pkg::LIMIT_W-1:0]         pair_limit,
	input  logic [ksps_pkg::MODE_W-1:0]          mode,
	input  logic signed [ksps_pkg::VAL_W-1:0]    value,
	input  ksps_pkg::ksps_cmd_t                  cmd,
	output ksps_pkg::ksps_status_t               status,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [ksps_pkg::VAL_W-1:0]    first_value,
	output logic signed [ksps_pkg::VAL_W-1:0]    second_value,
	output logic                                 pair_valid,
	output logic                                 last_result
);

	localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW  = $clog2(MAX_LEN + 1);
	localparam int XW  = IW + 2;
	localparam int HAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int HSW = $clog2(MAX_PAIRS + 1);
	localparam int EW  = ksps_pkg::SUM_W + 2 * IW;
	localparam int VW  = ksps_pkg::VAL_W;

	logic [CW-1:0]   count_first_q, count_second_q;
	logic            swap_q;
	logic [ksps_pkg::LIMIT_W-1:0] limit_q;
	logic [HSW-1:0]  k_q, emit_q, size_q, scan_q;
	logic            pend_s1, has_q;
	logic [HAW-1:0]  idx_s1, best_idx_q;
	logic [EW-1:0]   best_q;
	logic            out_valid_q, out_pv_q, out_last_q;
	logic [VW-1:0]   out_first_q, out_second_q;

	logic [CW-1:0]   nr, nc;
	logic [IW-1:0]   best_row, best_col, row_a, col_a;
	logic [IW-1:0]   first_raddr, second_raddr;
	logic [VW-1:0]   first_rd, second_rd, row_val, col_val;
	logic            first_we, second_we;
	logic [ksps_pkg::SUM_W-1:0] sum;
	logic [EW-1:0]   entry, heap_rd, heap_wdata;
	logic [HAW-1:0]  heap_raddr, heap_waddr;
	logic            heap_we;
	logic [HSW-1:0]  size_dec;
	logic            out_free;

	assign nr       = swap_q ? count_second_q : count_first_q;
	assign nc       = swap_q ? count_first_q : count_second_q;
	assign best_row = best_q[2*IW-1:IW];
	assign best_col = best_q[IW-1:0];
	assign size_dec = size_q - HSW'(1);

	// pick list addresses for the requested pair
	always_comb begin
		case (cmd.list_sel)
			ksps_pkg::LS_ORIGIN: begin
				row_a = '0;
				col_a = '0;
			end
			ksps_pkg::LS_BEST: begin
				row_a = best_row;
				col_a = best_col;
			end
			ksps_pkg::LS_RIGHT: begin
				row_a = best_row;
				col_a = best_col + IW'(1);
			end
			ksps_pkg::LS_DOWN: begin
				row_a = best_row + IW'(1);
				col_a = '0;
			end
			default: begin
				row_a = '0;
				col_a = '0;
			end
		endcase
	end

	assign first_raddr  = swap_q ? col_a : row_a;
	assign second_raddr = swap_q ? row_a : col_a;
	assign first_we  = cmd.load && (mode == ksps_pkg::MODE_FIRST)
		&& (count_first_q < CW'(MAX_LEN));
	assign second_we = cmd.load && (mode == ksps_pkg::MODE_SECOND)
		&& (count_second_q < CW'(MAX_LEN));

	ksps_ram #(.WIDTH(VW), .DEPTH(MAX_LEN)) u_first_ram (
		.clk   (clk),
		.we    (first_we),
		.waddr (count_first_q[IW-1:0]),
		.wdata (value),
		.raddr (first_raddr),
		.rdata (first_rd)
	);

	ksps_ram #(.WIDTH(VW), .DEPTH(MAX_LEN)) u_second_ram (
		.clk   (clk),
		.we    (second_we),
		.waddr (count_second_q[IW-1:0]),
		.wdata (value),
		.raddr (second_raddr),
		.rdata (second_rd)
	);

	// form the candidate key; flipped sign bit makes an unsigned compare exact
	assign row_val = swap_q ? second_rd : first_rd;
	assign col_val = swap_q ? first_rd : second_rd;
	assign sum     = {row_val[VW-1], row_val} + {col_val[VW-1], col_val};
	assign entry   = {~sum[ksps_pkg::SUM_W-1], sum[ksps_pkg::SUM_W-2:0], row_a, col_a};

	assign heap_raddr = cmd.heap_rm_rd ? size_dec[HAW-1:0] : scan_q[HAW-1:0];
	assign heap_we    = cmd.heap_push || cmd.heap_move;
	assign heap_waddr = cmd.heap_move ? best_idx_q : size_q[HAW-1:0];
	assign heap_wdata = cmd.heap_move ? heap_rd : entry;

	ksps_ram #(.WIDTH(EW), .DEPTH(MAX_PAIRS)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.raddr (heap_raddr),
		.rdata (heap_rd)
	);

	// status toward the controller
	assign out_free = !out_valid_q || !result_stall;
	always_comb begin
		status.run_empty = (count_first_q == '0) || (count_second_q == '0)
			|| (limit_q == '0);
		status.scan_done = (scan_q == size_q) && !pend_s1;
		status.out_free  = out_free;
		status.can_right = (XW'(best_col) + XW'(1)) < XW'(nc);
		status.can_down  = (best_col == '0) && ((XW'(best_row) + XW'(1)) < XW'(nr));
		status.is_last   = ((HSW+1)'(emit_q) + (HSW+1)'(1) == (HSW+1)'(k_q))
			|| ((size_q == '0) && !status.can_right && !status.can_down);
	end

	// control registers: counts, limit, heap size, scan and emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_first_q  <= '0;
			count_second_q <= '0;
			limit_q        <= ksps_pkg::LIMIT_W'(1);
			swap_q         <= 1'b0;
			k_q            <= '0;
			emit_q         <= '0;
			size_q         <= '0;
			scan_q         <= '0;
			pend_s1        <= 1'b0;
			has_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= pair_limit;
			end
			if (first_we) begin
				count_first_q <= count_first_q + CW'(1);
			end
			if (second_we) begin
				count_second_q <= count_second_q + CW'(1);
			end
			if (cmd.run_start) begin
				swap_q <= count_first_q > count_second_q;
				k_q    <= (limit_q > ksps_pkg::LIMIT_W'(MAX_PAIRS)) ? HSW'(MAX_PAIRS)
					: HSW'(limit_q);
				emit_q <= '0;
				size_q <= '0;
			end
			if (cmd.clear) begin
				count_first_q  <= '0;
				count_second_q <= '0;
				size_q         <= '0;
			end
			if (cmd.heap_push) begin
				size_q <= size_q + HSW'(1);
			end
			if (cmd.heap_rm_rd) begin
				size_q <= size_dec;
			end
			if (cmd.scan_init) begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
				has_q   <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (scan_q < size_q) begin
					scan_q  <= scan_q + HSW'(1);
					pend_s1 <= 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
				if (pend_s1 && (!has_q || (heap_rd < best_q))) begin
					has_q <= 1'b1;
				end
			end
			if (cmd.out_load && !cmd.out_empty) begin
				emit_q <= emit_q + HSW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan payload: track the smallest candidate seen so far
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			idx_s1 <= scan_q[HAW-1:0];
			if (pend_s1 && (!has_q || (heap_rd < best_q))) begin
				best_q     <= heap_rd;
				best_idx_q <= idx_s1;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_empty) begin
				out_first_q  <= '0;
				out_second_q <= '0;
				out_pv_q     <= 1'b0;
				out_last_q   <= 1'b1;
			end else begin
				out_first_q  <= swap_q ? col_val : row_val;
				out_second_q <= swap_q ? row_val : col_val;
				out_pv_q     <= 1'b1;
				out_last_q   <= status.is_last;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign first_value  = out_first_q;
	assign second_value = out_second_q;
	assign pair_valid   = out_pv_q;
	assign last_result  = out_last_q;

endmodule

FILE: src/ksps_ctrl.sv
// ----------------------------------------------------------------------------
// ksps_ctrl
// Controller: sequences loads, candidate scans, removal, result issue and
// the pushes of the next candidates.
// ----------------------------------------------------------------------------
module ksps_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [ksps_pkg::MODE_W-1:0] mode,
	input  ksps_pkg::ksps_status_t      status,
	output ksps_pkg::ksps_cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EMPTY,
		S_INIT_RD,
		S_INIT_WR,
		S_SCAN0,
		S_SCAN,
		S_REMOVE,
		S_MOVE,
		S_EMIT,
		S_R_RD,
		S_R_WR,
		S_D_RD,
		S_D_WR
	} state_t;

	state_t state_q, state_d;

	assign item_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.list_sel = ksps_pkg::LS_BEST;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					case (mode)
						ksps_pkg::MODE_FIRST, ksps_pkg::MODE_SECOND: begin
							cmd.load = 1'b1;
						end
						ksps_pkg::MODE_RUN: begin
							cmd.run_start = 1'b1;
							state_d = status.run_empty ? S_EMPTY : S_INIT_RD;
						end
						default: begin
						end
					endcase
				end
			end
			S_EMPTY: begin
				if (status.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_empty = 1'b1;
					cmd.clear     = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_INIT_RD: begin
				cmd.list_sel = ksps_pkg::LS_ORIGIN;
				state_d      = S_INIT_WR;
			end
			S_INIT_WR: begin
				cmd.list_sel  = ksps_pkg::LS_ORIGIN;
				cmd.heap_push = 1'b1;
				state_d       = S_SCAN0;
			end
			S_SCAN0: begin
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				if (status.scan_done) begin
					state_d = S_REMOVE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_REMOVE: begin
				cmd.heap_rm_rd = 1'b1;
				state_d        = S_MOVE;
			end
			S_MOVE: begin
				cmd.heap_move = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.is_last) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else if (status.can_right) begin
						state_d = S_R_RD;
					end else if (status.can_down) begin
						state_d = S_D_RD;
					end else begin
						state_d = S_SCAN0;
					end
				end
			end
			S_R_RD: begin
				cmd.list_sel = ksps_pkg::LS_RIGHT;
				state_d      = S_R_WR;
			end
			S_R_WR: begin
				cmd.list_sel  = ksps_pkg::LS_RIGHT;
				cmd.heap_push = 1'b1;
				state_d       = status.can_down ? S_D_RD : S_SCAN0;
			end
			S_D_RD: begin
				cmd.list_sel = ksps_pkg::LS_DOWN;
				state_d      = S_D_WR;
			end
			S_D_WR: begin
				cmd.list_sel  = ksps_pkg::LS_DOWN;
				cmd.heap_push = 1'b1;
				state_d       = S_SCAN0;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/k_smallest_pair_sums_unit.sv
// Load items are accepted one per cycle while no run is in progress. For
// each emitted pair a run scans the candidate memory linearly at one entry
// per cycle, drains and finishes the scan (size is at most the pair count
// so far plus one), then does removal, issue, and up to two pushes, each a
// read state and a write state; the scan port sets the rate.
// Reset clears the list counts, the candidate count and the result valid
// flag, sets the limit to 1; list and candidate memories are not cleared.
// ----------------------------------------------------------------------------
// k_smallest_pair_sums_unit
// Emits up to pair_limit pairs from two loaded lists in order of smallest
// sum, using a candidate memory with a frontier expansion from column zero.
// ----------------------------------------------------------------------------
module k_smallest_pair_sums_unit #(
	parameter int MAX_LEN   = 64,
	parameter int MAX_PAIRS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ksps_pkg::LIMIT_W-1:0]      pair_limit,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [ksps_pkg::MODE_W-1:0]       mode,
	input  logic signed [ksps_pkg::VAL_W-1:0] value,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [ksps_pkg::VAL_W-1:0] first_value,
	output logic signed [ksps_pkg::VAL_W-1:0] second_value,
	output logic                              pair_valid,
	output logic                              last_result
);

	ksps_pkg::ksps_cmd_t    cmd;
	ksps_pkg::ksps_status_t status;

	assign cfg_ready = 1'b1;

	ksps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.status     (status),
		.cmd        (cmd)
	);

	ksps_dp #(.MAX_LEN(MAX_LEN), .MAX_PAIRS(MAX_PAIRS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.pair_limit   (pair_limit),
		.mode         (mode),
		.value        (value),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.first_value  (first_value),
		.second_value (second_value),
		.pair_valid   (pair_valid),
		.last_result  (last_result)
	);

	// never overwrite a result that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result register loaded while occupied");

	// a non-final pair keeps the block busy
	a_busy_after_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && !cmd.out_empty && !status.is_last |=> item_stall)
		else $error("block went idle before the final pair");

	// the empty marker always closes its run
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pair_valid |-> last_result)
		else $error("empty marker without last flag");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for k_smallest_pair_sums_unit: loads two lists, runs the
// pair search under several limits and compares every pair against a local
// heap-based predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN = 64;
	localparam int PAIRS = 64;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [ksps_pkg::VAL_W-1:0] fv;
		logic signed [ksps_pkg::VAL_W-1:0] sv;
		logic                              pv;
		logic                              last;
	} pair_t;

	typedef struct {
		logic signed [ksps_pkg::SUM_W-1:0] sum;
		int                                row;
		int                                col;
	} cand_t;

	typedef struct {
		logic [ksps_pkg::MODE_W-1:0] m;
		logic [ksps_pkg::VAL_W-1:0]  v;
		bit                          has_exp;
		pair_t                       exp_pair;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [ksps_pkg::LIMIT_W-1:0] pair_limit = 0;
	logic item_valid = 0, item_stall;
	logic [ksps_pkg::MODE_W-1:0] mode = 0;
	logic signed [ksps_pkg::VAL_W-1:0] value = 0;
	logic result_valid, result_stall = 1;
	logic signed [ksps_pkg::VAL_W-1:0] first_value, second_value;
	logic pair_valid, last_result;

	k_smallest_pair_sums_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pair_limit(pair_limit),
		.item_valid(item_valid), .item_stall(item_stall), .mode(mode), .value(value),
		.result_valid(result_valid), .result_stall(result_stall),
		.first_value(first_value), .second_value(second_value),
		.pair_valid(pair_valid), .last_result(last_result)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// predictor state
	logic [ksps_pkg::VAL_W-1:0] lst_a[LEN], lst_b[LEN];
	int cnt_a, cnt_b, limit_q;
	cand_t heap_q[$];
	pair_t pending_pairs[$];

	int errors = 0, mismatches = 0, cycles = 0;
	bit quiet = 0;	// long stretch with no idling
	bit hold_off = 0;

	function automatic bit cand_lt(cand_t a, cand_t b);
		if (a.sum != b.sum) return a.sum < b.sum;
		if (a.row != b.row) return a.row < b.row;
		return a.col < b.col;
	endfunction

	// pop the smallest candidate (order equals heap order since key is total)
	function automatic cand_t pop_min();
		int best;
		cand_t c;
		best = 0;
		for (int i = 1; i < heap_q.size(); i++)
			if (cand_lt(heap_q[i], heap_q[best])) best = i;
		c = heap_q[best];
		heap_q.delete(best);
		return c;
	endfunction

	function automatic logic signed [ksps_pkg::SUM_W-1:0] add33(
		logic [ksps_pkg::VAL_W-1:0] x, logic [ksps_pkg::VAL_W-1:0] y);
		return ksps_pkg::SUM_W'($signed(x)) + ksps_pkg::SUM_W'($signed(y));
	endfunction

	// compute the pairs of one item and queue them
	task automatic predict_item(logic [ksps_pkg::MODE_W-1:0] m,
		logic [ksps_pkg::VAL_W-1:0] v);
		int k, nr, nc, n;
		bit swp;
		cand_t c, d;
		logic [ksps_pkg::VAL_W-1:0] rv, cv;
		pair_t p;
		if (m == ksps_pkg::MODE_FIRST) begin
			if (cnt_a < LEN) lst_a[cnt_a++] = v;
			return;
		end
		if (m == ksps_pkg::MODE_SECOND) begin
			if (cnt_b < LEN) lst_b[cnt_b++] = v;
			return;
		end
		if (m != ksps_pkg::MODE_RUN) return;
		k = (limit_q > PAIRS) ? PAIRS : limit_q;
		swp = cnt_a > cnt_b;
		nr = swp ? cnt_b : cnt_a;
		nc = swp ? cnt_a : cnt_b;
		if (nr == 0 || nc == 0 || k == 0) begin
			p = '{fv: 0, sv: 0, pv: 0, last: 1};
			pending_pairs.push_back(p);
		end else begin
			heap_q.delete();
			n = 0;
			c.sum = swp ? add33(lst_b[0], lst_a[0]) : add33(lst_a[0], lst_b[0]);
			c.row = 0; c.col = 0;
			heap_q.push_back(c);
			while (heap_q.size() > 0 && n < k) begin
				c = pop_min();
				rv = swp ? lst_b[c.row] : lst_a[c.row];
				cv = swp ? lst_a[c.col] : lst_b[c.col];
				p.fv = swp ? cv : rv;
				p.sv = swp ? rv : cv;
				p.pv = 1;
				p.last = 0;
				pending_pairs.push_back(p);
				n++;
				if (c.col + 1 < nc) begin
					d.row = c.row; d.col = c.col + 1;
					d.sum = add33(rv, swp ? lst_a[d.col] : lst_b[d.col]);
					heap_q.push_back(d);
				end
				if (c.col == 0 && c.row + 1 < nr) begin
					d.row = c.row + 1; d.col = 0;
					d.sum = add33(swp ? lst_b[d.row] : lst_a[d.row], cv);
					heap_q.push_back(d);
				end
			end
			pending_pairs[pending_pairs.size() - 1].last = 1;
		end
		cnt_a = 0;
		cnt_b = 0;
	endtask

	// offer one item and wait for acceptance; valid stays up for the next item
	task automatic send_item(logic [ksps_pkg::MODE_W-1:0] m, logic [ksps_pkg::VAL_W-1:0] v);
		while (!quiet && $urandom_range(99) < 20) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		mode <= m;
		value <= v;
		do @(posedge clk); while (item_stall);
		predict_item(m, v);
	endtask

	task automatic write_limit(int lim);
		int w;
		w = 0;
		item_valid <= 0;
		while (pending_pairs.size() > 0 && w < CYCLE_LIMIT) begin
			@(posedge clk);
			w++;
		end
		repeat (600) @(posedge clk);	// drain any run still in flight
		cfg_valid <= 1;
		pair_limit <= lim[ksps_pkg::LIMIT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		limit_q = lim;
	endtask

	// random list of n values, mostly sorted, sometimes wild
	task automatic load_list(logic [ksps_pkg::MODE_W-1:0] m, int n, bit sorted);
		logic [ksps_pkg::VAL_W-1:0] base;
		base = $urandom_range(1) ? $urandom : $urandom_range(40) - 20;
		for (int i = 0; i < n; i++) begin
			send_item(m, sorted ? base : $urandom);
			if (sorted) base = base + $urandom_range(5);
		end
	endtask

	// receiver: random stalls plus a hold-off window
	always @(posedge clk) begin
		if (hold_off) result_stall <= 1;
		else result_stall <= quiet ? 0 : ($urandom_range(99) < 20);
	end

	// result checker
	always @(posedge clk) begin
		pair_t got, want;
		cycles <= cycles + 1;
		if (arst_n && result_valid && !result_stall) begin
			got = '{fv: first_value, sv: second_value, pv: pair_valid, last: last_result};
			if (pending_pairs.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected pair %h", got);
			end else begin
				want = pending_pairs.pop_front();
				if (got !== want) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp f=%0d s=%0d v=%b l=%b %s",
							want.fv, want.sv, want.pv, want.last,
							$sformatf("got f=%0d s=%0d v=%b l=%b",
								got.fv, got.sv, got.pv, got.last));
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	row_t dir_tbl[$];

	initial begin
		int lims[6];
		int w;
		cnt_a = 0; cnt_b = 0; limit_q = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: empty runs, extremes, unused mode
		dir_tbl.push_back('{ksps_pkg::MODE_RUN, 0, 1, '{0, 0, 0, 1}});
		dir_tbl.push_back('{ksps_pkg::MODE_FIRST, 32'h8000_0000, 0, '0});
		dir_tbl.push_back('{ksps_pkg::MODE_RUN, 0, 1, '{0, 0, 0, 1}});
		dir_tbl.push_back('{ksps_pkg::MODE_SECOND, 32'h7fff_ffff, 0, '0});
		dir_tbl.push_back('{ksps_pkg::MODE_RUN, 32'hffff_ffff, 1, '{0, 0, 0, 1}});
		dir_tbl.push_back('{ksps_pkg::MODE_FIRST, 32'h7fff_ffff, 0, '0});
		dir_tbl.push_back('{ksps_pkg::MODE_SECOND, 32'h7fff_ffff, 0, '0});
		dir_tbl.push_back('{ksps_pkg::MODE_RUN, 0, 1,
			'{32'h7fff_ffff, 32'h7fff_ffff, 1, 1}});
		dir_tbl.push_back('{2'd3, 32'h1234_5678, 0, '0});
		dir_tbl.push_back('{ksps_pkg::MODE_FIRST, 32'h8000_0000, 0, '0});
		dir_tbl.push_back('{ksps_pkg::MODE_SECOND, 32'h8000_0000, 0, '0});
		dir_tbl.push_back('{ksps_pkg::MODE_RUN, 0, 1,
			'{32'h8000_0000, 32'h8000_0000, 1, 1}});
		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].has_exp) begin
				send_item(dir_tbl[i].m, dir_tbl[i].v);
				if (pending_pairs[pending_pairs.size() - 1] !== dir_tbl[i].exp_pair) begin
					errors++;
					$display("table row %0d predicts %h", i, pending_pairs[$]);
				end
			end else
				send_item(dir_tbl[i].m, dir_tbl[i].v);
		end

		// limit 0 gives the empty marker; then the largest limit over full lists
		write_limit(0);
		send_item(ksps_pkg::MODE_FIRST, 5);
		send_item(ksps_pkg::MODE_SECOND, 6);
		send_item(ksps_pkg::MODE_RUN, 0);
		write_limit(127);
		load_list(ksps_pkg::MODE_FIRST, 66, 1);	// two dropped loads
		load_list(ksps_pkg::MODE_SECOND, 66, 1);
		send_item(ksps_pkg::MODE_RUN, 0);

		// random runs under several limits
		lims = '{64, 1, 7, 100, 3, 20};
		for (int ph = 0; ph < 6; ph++) begin
			write_limit(lims[ph]);
			for (int r = 0; r < 6; r++) begin
				quiet = (ph == 2);
				if (ph == 4 && r == 0) begin
					fork
						begin
							hold_off = 1;
							repeat (400) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				if ($urandom_range(9) == 0) begin
					// noise: interleaved loads and runs, unused mode, unsorted content
					repeat ($urandom_range(8))
						send_item(ksps_pkg::MODE_W'($urandom_range(3)), $urandom);
				end else begin
					load_list(ksps_pkg::MODE_FIRST, $urandom_range(1, 6),
						$urandom_range(9) != 0);
					load_list(ksps_pkg::MODE_SECOND, $urandom_range(0, 6),
						$urandom_range(9) != 0);
				end
				send_item(ksps_pkg::MODE_RUN, $urandom);
			end
		end
		quiet = 0;
		item_valid <= 0;

		w = 0;
		while (pending_pairs.size() > 0 && w < CYCLE_LIMIT) begin
			@(posedge clk);
			w++;
		end
		repeat (600) @(posedge clk);
		if (errors == 0 && pending_pairs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

FILE: filelist.f
src/ksps_pkg.sv
src/ksps_ram.sv
src/ksps_dp.sv
src/ksps_ctrl.sv
src/k_smallest_pair_sums_unit.sv
tb/testbench.sv
